FILE: rtl/elev_pkg.sv
package elev_pkg;

  localparam int POSITION_BITS = 4;
  localparam int COUNT_BITS    = 8;
  localparam int CFG_BITS      = 8;
  localparam int CFG_IDX_BITS  = 2;
  localparam int ACTION_BITS   = 2;
  localparam int CALL_BITS     = 4;
  localparam int MODE_BITS     = 3;
  localparam int CMP_BITS      = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [POSITION_BITS-1:0] POS_RESET = POSITION_BITS'(2);

  localparam logic [CFG_BITS-1:0] TPHF_RESET  = CFG_BITS'(10);
  localparam logic [CFG_BITS-1:0] DOOR_RESET  = CFG_BITS'(60);
  localparam logic [CFG_BITS-1:0] FLASH_RESET = CFG_BITS'(4);

  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_TPHF  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_DOOR  = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_FLASH = CFG_IDX_BITS'(2);

  localparam logic [ACTION_BITS-1:0] ACT_TICK   = ACTION_BITS'(0);
  localparam logic [ACTION_BITS-1:0] ACT_CALL   = ACTION_BITS'(1);
  localparam logic [ACTION_BITS-1:0] ACT_TOGGLE = ACTION_BITS'(2);

  localparam logic [MODE_BITS-1:0] MCODE_IDLE    = MODE_BITS'(0);
  localparam logic [MODE_BITS-1:0] MCODE_CLOSING = MODE_BITS'(1);
  localparam logic [MODE_BITS-1:0] MCODE_RUNNING = MODE_BITS'(2);
  localparam logic [MODE_BITS-1:0] MCODE_OPENING = MODE_BITS'(3);
  localparam logic [MODE_BITS-1:0] MCODE_CONFIG  = MODE_BITS'(4);

  localparam int LAMP_CLOSE = 0;
  localparam int LAMP_RUN   = 1;
  localparam int LAMP_OPEN  = 2;

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_CLOSING = 5'b00010,
    MODE_RUNNING = 5'b00100,
    MODE_OPENING = 5'b01000,
    MODE_CONFIG  = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] tphf;
    logic [CFG_BITS-1:0] door;
    logic [CFG_BITS-1:0] flash;
  } cfg_t;

  typedef struct packed {
    mode_t                   mode;
    logic [POSITION_BITS-1:0] cab;
    logic [POSITION_BITS-1:0] target;
    logic [POSITION_BITS-1:0] pending;
    logic [COUNT_BITS-1:0]    phase;
    logic [COUNT_BITS-1:0]    blink;
    logic [2:0]               lamps;
  } state_t;

  function automatic logic reached(logic [COUNT_BITS-1:0] count, logic [CFG_BITS-1:0] limit);
    return (CMP_BITS'(count) >= CMP_BITS'(limit)) || (count == CNT_MAX);
  endfunction

  function automatic logic [MODE_BITS-1:0] mode_code(mode_t m);
    logic [MODE_BITS-1:0] code;
    case (m)
      MODE_IDLE:    code = MCODE_IDLE;
      MODE_CLOSING: code = MCODE_CLOSING;
      MODE_RUNNING: code = MCODE_RUNNING;
      MODE_OPENING: code = MCODE_OPENING;
      MODE_CONFIG:  code = MCODE_CONFIG;
      default:      code = MCODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/elevator_door_and_travel_controller.sv
// Elevator door and travel controller.
// Input channel (in_valid / in_stall): one item per event, in_action selects a
// timer tick, a floor call to in_call_position (half-floor units) or a config
// mode toggle. Result channel (out_valid / out_stall): one item per input item,
// showing mode, cab position, the three lamps and whether a call is reserved,
// all as they stand after that event.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 travel ticks
// per half-floor, 1 door ticks, 2 flash ticks); other indexes are dropped.
// An accepted item is loaded into the input register; when it advances, the
// next-state logic runs into the controller state and the result register,
// which drives out_valid.
// Throughput is one item per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds; the input register
// holds its item behind it and in_stall rises until the result is taken.
// Reset (rst_n low, synchronous) empties both registers, puts the cab idle at
// position 2 with lamps off and no reservation, and reloads register defaults.
module elevator_door_and_travel_controller (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [elev_pkg::ACTION_BITS-1:0]     in_action,
  input  logic [elev_pkg::CALL_BITS-1:0]       in_call_position,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [elev_pkg::MODE_BITS-1:0]       out_mode,
  output logic [elev_pkg::POSITION_BITS-1:0]   out_position,
  output logic                                 out_closing_lamp,
  output logic                                 out_running_lamp,
  output logic                                 out_opening_lamp,
  output logic                                 out_has_reservation,
  input  logic                                 cfg_we,
  input  logic [elev_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [elev_pkg::CFG_BITS-1:0]        cfg_data
);

  elev_pkg::cfg_t   cfg;
  elev_pkg::state_t state_r;
  elev_pkg::state_t state_nxt;
  elev_pkg::state_t step_out;

  logic                                 s1_valid_r;
  logic                                 s1_valid_nxt;
  logic [elev_pkg::ACTION_BITS-1:0]     s1_action_r;
  logic [elev_pkg::POSITION_BITS-1:0]   s1_pos_r;
  logic                                 out_valid_r;
  logic                                 out_valid_nxt;
  logic [elev_pkg::MODE_BITS-1:0]       out_mode_r;
  logic [elev_pkg::POSITION_BITS-1:0]   out_position_r;
  logic [2:0]                           out_lamps_r;
  logic                                 out_resv_r;
  logic                                 advance;
  logic                                 in_accept;

  elev_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  elev_step u_step (
    .cur    (state_r),
    .cfg    (cfg),
    .action (s1_action_r),
    .pos    (s1_pos_r),
    .nxt    (step_out)
  );

  // move the staged item into the state when the result register is free or its result is being taken
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  assign s1_valid_nxt  = in_accept || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);
  assign state_nxt     = advance ? step_out : state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      state_r.mode    <= elev_pkg::MODE_IDLE;
      state_r.cab     <= elev_pkg::POS_RESET;
      state_r.target  <= elev_pkg::POS_RESET;
      state_r.pending <= '0;
      state_r.phase   <= '0;
      state_r.blink   <= '0;
      state_r.lamps   <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action_r <= in_action;
      s1_pos_r    <= elev_pkg::POSITION_BITS'(in_call_position);
    end
    if (advance) begin
      out_mode_r     <= elev_pkg::mode_code(step_out.mode);
      out_position_r <= step_out.cab;
      out_lamps_r    <= step_out.lamps;
      out_resv_r     <= (step_out.pending != '0);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_mode            = out_mode_r;
  assign out_position        = out_position_r;
  assign out_closing_lamp    = out_lamps_r[elev_pkg::LAMP_CLOSE];
  assign out_running_lamp    = out_lamps_r[elev_pkg::LAMP_RUN];
  assign out_opening_lamp    = out_lamps_r[elev_pkg::LAMP_OPEN];
  assign out_has_reservation = out_resv_r;

  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("controller state changed without an item");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("item advanced but no result is held");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  a_close_lamp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.lamps[elev_pkg::LAMP_CLOSE] |-> (state_r.mode == elev_pkg::MODE_CLOSING))
    else $error("closing lamp lit outside door closing");

  a_open_lamp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.lamps[elev_pkg::LAMP_OPEN] |-> (state_r.mode == elev_pkg::MODE_OPENING))
    else $error("opening lamp lit outside door opening");

endmodule

FILE: rtl/elev_cfg_regs.sv
module elev_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             we,
  input  logic [elev_pkg::CFG_IDX_BITS-1:0] index,
  input  logic [elev_pkg::CFG_BITS-1:0]     data,
  output elev_pkg::cfg_t                   cfg
);

  elev_pkg::cfg_t cfg_r;
  elev_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (we) begin
      case (index)
        elev_pkg::CFG_IDX_TPHF:  cfg_nxt.tphf  = data;
        elev_pkg::CFG_IDX_DOOR:  cfg_nxt.door  = data;
        elev_pkg::CFG_IDX_FLASH: cfg_nxt.flash = data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tphf  <= elev_pkg::TPHF_RESET;
      cfg_r.door  <= elev_pkg::DOOR_RESET;
      cfg_r.flash <= elev_pkg::FLASH_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/elev_step.sv
module elev_step (
  input  elev_pkg::state_t                   cur,
  input  elev_pkg::cfg_t                     cfg,
  input  logic [elev_pkg::ACTION_BITS-1:0]   action,
  input  logic [elev_pkg::POSITION_BITS-1:0] pos,
  output elev_pkg::state_t                   nxt
);

  logic [elev_pkg::COUNT_BITS-1:0] phase_inc;
  logic [elev_pkg::COUNT_BITS-1:0] blink_inc;

  assign phase_inc = (cur.phase == elev_pkg::CNT_MAX) ? cur.phase
                     : elev_pkg::COUNT_BITS'(cur.phase + 1'b1);
  assign blink_inc = (cur.blink == elev_pkg::CNT_MAX) ? cur.blink
                     : elev_pkg::COUNT_BITS'(cur.blink + 1'b1);

  always_comb begin
    nxt = cur;
    case (action)
      elev_pkg::ACT_TICK: begin
        nxt.phase = phase_inc;
        nxt.blink = blink_inc;
        case (cur.mode)
          elev_pkg::MODE_CLOSING: begin
            if (elev_pkg::reached(blink_inc, cfg.flash)) begin
              nxt.lamps[elev_pkg::LAMP_CLOSE] = ~cur.lamps[elev_pkg::LAMP_CLOSE];
              nxt.blink = '0;
            end
            if (elev_pkg::reached(phase_inc, cfg.door)) begin
              nxt.phase = '0;
              nxt.blink = '0;
              nxt.lamps[elev_pkg::LAMP_CLOSE] = 1'b0;
              nxt.mode = elev_pkg::MODE_RUNNING;
            end
          end
          elev_pkg::MODE_RUNNING: begin
            if (elev_pkg::reached(blink_inc, cfg.flash)) begin
              nxt.lamps[elev_pkg::LAMP_RUN] = ~cur.lamps[elev_pkg::LAMP_RUN];
              nxt.blink = '0;
            end
            if (elev_pkg::reached(phase_inc, cfg.tphf)) begin
              nxt.phase = '0;
              nxt.blink = '0;
              if (cur.cab == cur.target) begin
                // arrival clears the opening lamp; the running lamp is not cleared
                nxt.lamps[elev_pkg::LAMP_OPEN] = 1'b0;
                nxt.mode = elev_pkg::MODE_OPENING;
              end else if (cur.cab > cur.target) begin
                nxt.cab = elev_pkg::POSITION_BITS'(cur.cab - 1'b1);
              end else begin
                nxt.cab = elev_pkg::POSITION_BITS'(cur.cab + 1'b1);
              end
            end
          end
          elev_pkg::MODE_OPENING: begin
            if (elev_pkg::reached(blink_inc, cfg.flash)) begin
              nxt.lamps[elev_pkg::LAMP_OPEN] = ~cur.lamps[elev_pkg::LAMP_OPEN];
              nxt.blink = '0;
            end
            if (elev_pkg::reached(phase_inc, cfg.door)) begin
              nxt.phase = '0;
              nxt.blink = '0;
              nxt.lamps[elev_pkg::LAMP_OPEN] = 1'b0;
              nxt.mode = elev_pkg::MODE_IDLE;
              // serve the reserved call from idle
              if (cur.pending != '0) begin
                nxt.pending = '0;
                if (cur.pending != cur.cab) begin
                  nxt.target = cur.pending;
                  nxt.mode = elev_pkg::MODE_CLOSING;
                end
              end
            end
          end
          default: ;
        endcase
      end
      elev_pkg::ACT_CALL: begin
        if (cur.mode == elev_pkg::MODE_IDLE) begin
          if (pos != cur.cab) begin
            nxt.target = pos;
            nxt.phase = '0;
            nxt.blink = '0;
            nxt.mode = elev_pkg::MODE_CLOSING;
          end
        end else if (cur.mode != elev_pkg::MODE_CONFIG) begin
          nxt.pending = pos;
        end
      end
      elev_pkg::ACT_TOGGLE: begin
        if (cur.mode == elev_pkg::MODE_IDLE) begin
          nxt.mode = elev_pkg::MODE_CONFIG;
        end else if (cur.mode == elev_pkg::MODE_CONFIG) begin
          nxt.mode = elev_pkg::MODE_IDLE;
        end
      end
      default: ;
    endcase
  end

endmodule
